// File: hdl/btseg_pkg.sv
// btseg_pkg: shared types and codes for the bulk transfer segmenter
// no dependencies; imported by every module of the block

package btseg_pkg;

  // item kinds
  typedef enum logic [1:0] {
    MODE_STEP = 2'd0,
    MODE_TX   = 2'd1,
    MODE_RX   = 2'd2
  } mode_t;

  // channel result codes
  typedef enum logic [1:0] {
    CH_IDLE  = 2'd0,
    CH_DONE  = 2'd1,
    CH_NAK   = 2'd2,
    CH_STALL = 2'd3
  } chan_res_t;

  // issued commands
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_SEND    = 3'd1,
    CMD_RESEND  = 3'd2,
    CMD_RECEIVE = 3'd3,
    CMD_CLR_OUT = 3'd4,
    CMD_CLR_IN  = 3'd5,
    CMD_TX_DONE = 3'd6,
    CMD_RX_DONE = 3'd7
  } cmd_t;

  // sequencer state, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_IN   = 3'b010,
    ST_OUT  = 3'b100
  } xfer_state_t;

  // pending request
  typedef enum logic [1:0] {
    REQ_NONE = 2'd0,
    REQ_TX   = 2'd1,
    REQ_RX   = 2'd2
  } req_t;

  // state codes as reported on state_now
  localparam logic [1:0] STATE_CODE_IDLE = 2'd0;
  localparam logic [1:0] STATE_CODE_IN   = 2'd1;
  localparam logic [1:0] STATE_CODE_OUT  = 2'd2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_OUT_PACKET_SIZE = 2'd0,
    CFG_IN_PACKET_SIZE  = 2'd1,
    CFG_POLL_INTERVAL   = 2'd2
  } cfg_index_t;

  localparam logic [9:0]  OUT_PACKET_SIZE_RESET = 10'd64;
  localparam logic [9:0]  IN_PACKET_SIZE_RESET  = 10'd64;
  localparam logic [15:0] POLL_INTERVAL_RESET   = 16'd10;

  typedef struct packed {
    logic [9:0]  out_packet_size;
    logic [9:0]  in_packet_size;
    logic [15:0] poll_interval;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [11:0] request_length;
    logic        connected;
    chan_res_t   chan_status;
    logic [31:0] now_time;
  } item_t;

  typedef struct packed {
    cmd_t        command;
    logic [12:0] packet_offset;
    logic [11:0] packet_length;
    logic [1:0]  state_now;
  } result_t;

endpackage

// File: hdl/btseg_cfg.sv
// btseg_cfg: configuration registers of the bulk transfer segmenter
// depends on btseg_pkg

module btseg_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output btseg_pkg::cfg_t   cfg
);
  import btseg_pkg::*;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.out_packet_size <= OUT_PACKET_SIZE_RESET;
      cfg.in_packet_size  <= IN_PACKET_SIZE_RESET;
      cfg.poll_interval   <= POLL_INTERVAL_RESET;
    end else if (cfg_write) begin
      case (cfg_index_t'(cfg_index))
        CFG_OUT_PACKET_SIZE: cfg.out_packet_size <= cfg_data[9:0];
        CFG_IN_PACKET_SIZE:  cfg.in_packet_size  <= cfg_data[9:0];
        CFG_POLL_INTERVAL:   cfg.poll_interval   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: hdl/btseg_seq.sv
// btseg_seq: transfer state registers and the per-item step logic
// depends on btseg_pkg; driven by the top level's input register

module btseg_seq #(
  parameter int unsigned MAX_TRANSFER = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  btseg_pkg::item_t   item,
  input  btseg_pkg::cfg_t    cfg,
  output btseg_pkg::result_t result
);
  import btseg_pkg::*;

  // stored request totals never exceed the request field or the transfer cap
  localparam int unsigned CapLen = (MAX_TRANSFER < 4095) ? MAX_TRANSFER : 4095;
  localparam int unsigned LenW   = $clog2(CapLen + 1);
  // a receive poll stores the in packet size as its total
  localparam int unsigned RxW    = (LenW > 10) ? LenW : 10;

  xfer_state_t     st, st_next;
  req_t            pend, pend_next;
  logic [LenW-1:0] tx_total, tx_total_next;
  logic [12:0]     tx_next_offset, tx_next_offset_next;
  logic [12:0]     tx_prev_offset, tx_prev_offset_next;
  logic [RxW-1:0]  rx_total, rx_total_next;
  logic [12:0]     rx_next_offset, rx_next_offset_next;
  logic [31:0]     last_rx_time, last_rx_time_next;

  logic [LenW-1:0] req_clamped;
  logic [12:0]     tx_total_ext;
  logic [12:0]     rx_total_ext;
  logic [31:0]     idle_ticks;
  logic [11:0]     seg;

  // bytes of the next out segment from base, capped at the packet size
  function automatic logic [11:0] seg_len(logic [12:0] total, logic [12:0] base,
                                          logic [9:0] size);
    logic [12:0] rem;
    rem = (total > base) ? (total - base) : 13'd0;
    if (rem > {3'b000, size}) rem = {3'b000, size};
    return rem[11:0];
  endfunction

  assign req_clamped  = (item.request_length > 12'(CapLen)) ? LenW'(CapLen)
                                                            : LenW'(item.request_length);
  assign tx_total_ext = 13'(tx_total);
  assign rx_total_ext = 13'(rx_total);
  assign idle_ticks   = item.now_time - last_rx_time;

  // one step of the sequencer
  always_comb begin
    st_next             = st;
    pend_next           = pend;
    tx_total_next       = tx_total;
    tx_next_offset_next = tx_next_offset;
    tx_prev_offset_next = tx_prev_offset;
    rx_total_next       = rx_total;
    rx_next_offset_next = rx_next_offset;
    last_rx_time_next   = last_rx_time;
    result.command       = CMD_NONE;
    result.packet_offset = 13'd0;
    result.packet_length = 12'd0;
    seg                  = 12'd0;

    case (item.mode)
      MODE_TX: begin
        tx_total_next = req_clamped;
        pend_next     = REQ_TX;
      end
      MODE_RX: begin
        rx_total_next = RxW'(req_clamped);
        pend_next     = REQ_RX;
      end
      MODE_STEP: begin
        if (item.connected) begin
          case (st)
            ST_IDLE: begin
              if (pend == REQ_TX) begin
                // first out segment from offset zero
                seg                 = seg_len(tx_total_ext, 13'd0, cfg.out_packet_size);
                tx_prev_offset_next = 13'd0;
                tx_next_offset_next = 13'(seg);
                if (seg != 12'd0) begin
                  result.command       = CMD_SEND;
                  result.packet_length = seg;
                end
                pend_next = REQ_NONE;
                st_next   = ST_OUT;
              end else if (pend == REQ_RX) begin
                rx_next_offset_next = 13'd0;
                if (rx_total != '0) begin
                  result.command       = CMD_RECEIVE;
                  result.packet_length = 12'(cfg.in_packet_size);
                  rx_next_offset_next  = 13'(cfg.in_packet_size);
                  last_rx_time_next    = item.now_time;
                end
                pend_next = REQ_NONE;
                st_next   = ST_IN;
              end else if (idle_ticks > {16'd0, cfg.poll_interval}) begin
                // receive poll of one packet
                rx_total_next       = RxW'(cfg.in_packet_size);
                rx_next_offset_next = 13'd0;
                if (cfg.in_packet_size != 10'd0) begin
                  result.command       = CMD_RECEIVE;
                  result.packet_length = 12'(cfg.in_packet_size);
                  rx_next_offset_next  = 13'(cfg.in_packet_size);
                  last_rx_time_next    = item.now_time;
                end
                st_next = ST_IN;
              end
            end
            ST_IN: begin
              case (item.chan_status)
                CH_DONE: begin
                  if (rx_total_ext > rx_next_offset) begin
                    result.command       = CMD_RECEIVE;
                    result.packet_offset = rx_next_offset;
                    result.packet_length = 12'(cfg.in_packet_size);
                    rx_next_offset_next  = rx_next_offset + 13'(cfg.in_packet_size);
                    last_rx_time_next    = item.now_time;
                  end else begin
                    result.command       = CMD_RX_DONE;
                    result.packet_length = 12'(rx_total);
                    last_rx_time_next    = item.now_time;
                    st_next              = ST_IDLE;
                  end
                end
                CH_STALL: begin
                  result.command = CMD_CLR_IN;
                  st_next        = ST_IDLE;
                end
                default: st_next = ST_IDLE;
              endcase
            end
            ST_OUT: begin
              case (item.chan_status)
                CH_DONE: begin
                  if (tx_total_ext > tx_next_offset) begin
                    seg = seg_len(tx_total_ext, tx_next_offset, cfg.out_packet_size);
                    if (seg != 12'd0) begin
                      result.command       = CMD_SEND;
                      result.packet_offset = tx_next_offset;
                      result.packet_length = seg;
                      tx_prev_offset_next  = tx_next_offset;
                      tx_next_offset_next  = tx_next_offset + 13'(seg);
                    end
                  end else begin
                    result.command       = CMD_TX_DONE;
                    result.packet_length = 12'(tx_total);
                    st_next              = ST_IDLE;
                    tx_total_next        = '0;
                    tx_next_offset_next  = 13'd0;
                    tx_prev_offset_next  = 13'd0;
                  end
                end
                CH_NAK: begin
                  // repeat the last out segment
                  seg = seg_len(tx_total_ext, tx_prev_offset, cfg.out_packet_size);
                  if (seg != 12'd0) begin
                    result.command       = CMD_RESEND;
                    result.packet_offset = tx_prev_offset;
                    result.packet_length = seg;
                  end
                end
                CH_STALL: begin
                  result.command = CMD_CLR_OUT;
                  st_next        = ST_IDLE;
                end
                default: ;
              endcase
            end
            default: st_next = ST_IDLE;
          endcase
        end
      end
      default: ;
    endcase

    case (st_next)
      ST_IN:   result.state_now = STATE_CODE_IN;
      ST_OUT:  result.state_now = STATE_CODE_OUT;
      default: result.state_now = STATE_CODE_IDLE;
    endcase
  end

  // state registers, updated once per stepped item
  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_IDLE;
      pend           <= REQ_NONE;
      tx_total       <= '0;
      tx_next_offset <= 13'd0;
      tx_prev_offset <= 13'd0;
      rx_total       <= '0;
      rx_next_offset <= 13'd0;
      last_rx_time   <= 32'd0;
    end else if (step_en) begin
      st             <= st_next;
      pend           <= pend_next;
      tx_total       <= tx_total_next;
      tx_next_offset <= tx_next_offset_next;
      tx_prev_offset <= tx_prev_offset_next;
      rx_total       <= rx_total_next;
      rx_next_offset <= rx_next_offset_next;
      last_rx_time   <= last_rx_time_next;
    end
  end

endmodule

// File: hdl/bulk_transfer_segmenter_fsm.sv
// bulk_transfer_segmenter_fsm: top level of the bulk transfer segmenter
// depends on btseg_pkg, btseg_cfg and btseg_seq
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: a
//   handler step or a posted transmit or receive request. Output channel
//   (out_valid / out_stall) returns exactly one result per item: command,
//   packet offset, packet length and the state after the step.
//   Configuration registers are written through cfg_write / cfg_index /
//   cfg_data while no item is in flight.
//   An item is captured in the input register, the step is evaluated
//   combinationally against the state registers, and its result is
//   captured in the result register, which drives the output channel.
//   Throughput: one item per cycle while the receiver does not stall;
//   the only loop is the state register feedback through a single step
//   of compares, a clamp and a 13-bit add.
//   When the receiver stalls, the result register holds its value and the
//   input register fills; in_stall rises once both are occupied.
//   Reset clears both registers' valid flags, returns the sequencer to idle
//   with no pending request and zero offsets, and restores register defaults.

module bulk_transfer_segmenter_fsm #(
  parameter int unsigned MAX_TRANSFER = 4096
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [11:0] request_length,
  input  logic        connected,
  input  logic [1:0]  chan_status,
  input  logic [31:0] now_time,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  command,
  output logic [12:0] packet_offset,
  output logic [11:0] packet_length,
  output logic [1:0]  state_now,
  // configuration
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import btseg_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_valid;
  result_t step_res;
  result_t res_q;
  logic    advance;
  logic    in_take;

  btseg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // item moves on when the result register is free or being drained
  assign advance  = item_valid && !(out_valid && out_stall);
  assign in_stall = item_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_take) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_q.mode           <= mode_t'(mode);
      item_q.request_length <= request_length;
      item_q.connected      <= connected;
      item_q.chan_status    <= chan_res_t'(chan_status);
      item_q.now_time       <= now_time;
    end
  end

  btseg_seq #(
    .MAX_TRANSFER (MAX_TRANSFER)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .step_en (advance),
    .item    (item_q),
    .cfg     (cfg),
    .result  (step_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign command       = res_q.command;
  assign packet_offset = res_q.packet_offset;
  assign packet_length = res_q.packet_length;
  assign state_now     = res_q.state_now;

endmodule

// File: hdl/btseg_checker.sv
// btseg_checker: port-level checks of the bulk transfer segmenter
// depends on btseg_pkg; bound to bulk_transfer_segmenter_fsm below

module btseg_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  command,
  input logic [12:0] packet_offset,
  input logic [11:0] packet_length,
  input logic [1:0]  state_now
);
  import btseg_pkg::*;

  // nothing is offered right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result offered right after reset");

  // a stalled result stays and does not change
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(command) &&
      $stable(packet_offset) && $stable(packet_length) && $stable(state_now))
    else $error("stalled result changed");

  // completion and stall clearing end in idle with no offset
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == CMD_TX_DONE || command == CMD_RX_DONE ||
      command == CMD_CLR_OUT || command == CMD_CLR_IN)
      |-> state_now == STATE_CODE_IDLE && packet_offset == 13'd0)
    else $error("finishing command not in idle");

  // out packet commands leave the sequencer in data out with a nonzero length
  a_packet_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == CMD_SEND || command == CMD_RESEND)
      |-> state_now == STATE_CODE_OUT && packet_length != 12'd0)
    else $error("out packet issued outside data out");

endmodule

bind bulk_transfer_segmenter_fsm btseg_checker u_btseg_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .command       (command),
  .packet_offset (packet_offset),
  .packet_length (packet_length),
  .state_now     (state_now)
);

// File: tb/tb.sv
// tb: self-checking testbench for bulk_transfer_segmenter_fsm
// depends on btseg_pkg and the block's rtl; predicts each result in-line
// and checks every output transfer against it in order

`timescale 1ns / 100ps

module tb;
  import btseg_pkg::*;

  // mode code that the block ignores
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [11:0] request_length;
  logic        connected;
  logic [1:0]  chan_status;
  logic [31:0] now_time;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  command;
  logic [12:0] packet_offset;
  logic [11:0] packet_length;
  logic [1:0]  state_now;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  // predicted sequencer state
  xfer_state_t seq_state;
  req_t        seq_pending;
  logic [11:0] out_total;
  logic [12:0] out_next;
  logic [12:0] out_prev;
  logic [11:0] in_total;
  logic [12:0] in_next;
  logic [31:0] last_poll_time;
  logic [9:0]  out_max;
  logic [9:0]  in_max;
  logic [15:0] poll_ticks;

  result_t     predicted_commands[$];
  int          error_count = 0;
  int          hold_cycles = 0;
  bit          quiet = 1'b0;
  logic [31:0] tick;

  bulk_transfer_segmenter_fsm i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .request_length (request_length),
    .connected      (connected),
    .chan_status    (chan_status),
    .now_time       (now_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .command        (command),
    .packet_offset  (packet_offset),
    .packet_length  (packet_length),
    .state_now      (state_now),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // next out segment, clamped to the out packet size
  function automatic result_t send_next_segment();
    logic [12:0] seg_len;
    result_t     r;
    r = '0;
    seg_len = '0;
    if (out_total > out_next) seg_len = out_total - out_next;
    if (seg_len > out_max) seg_len = 13'(out_max);
    if (seg_len != 0) begin
      r.command = CMD_SEND;
      r.packet_offset = out_next;
      r.packet_length = seg_len[11:0];
      out_prev = out_next;
      out_next = out_next + seg_len;
    end
    return r;
  endfunction

  // next in packet, only while bytes remain
  function automatic result_t receive_next_segment(logic [31:0] now);
    result_t r;
    r = '0;
    if (in_total > in_next) begin
      r.command = CMD_RECEIVE;
      r.packet_offset = in_next;
      r.packet_length = 12'(in_max);
      in_next = in_next + 13'(in_max);
      last_poll_time = now;
    end
    return r;
  endfunction

  // one handler step or post, returns the expected result
  function automatic result_t segment_step(item_t it);
    logic [12:0] seg_len;
    result_t     r;
    r = '0;
    if (it.mode == MODE_TX) begin
      out_total = it.request_length;
      seq_pending = REQ_TX;
    end else if (it.mode == MODE_RX) begin
      in_total = it.request_length;
      seq_pending = REQ_RX;
    end else if (it.mode == MODE_STEP && it.connected) begin
      case (seq_state)
        ST_IDLE: begin
          if (seq_pending == REQ_TX) begin
            out_next = '0;
            out_prev = '0;
            r = send_next_segment();
            seq_pending = REQ_NONE;
            seq_state = ST_OUT;
          end else if (seq_pending == REQ_RX) begin
            in_next = '0;
            r = receive_next_segment(it.now_time);
            seq_pending = REQ_NONE;
            seq_state = ST_IN;
          end else if ((it.now_time - last_poll_time) > 32'(poll_ticks)) begin
            // idle too long: one-packet receive poll
            in_next = '0;
            in_total = 12'(in_max);
            r = receive_next_segment(it.now_time);
            seq_state = ST_IN;
          end
        end
        ST_IN: begin
          if (it.chan_status == CH_DONE) begin
            if (in_total > in_next) begin
              r = receive_next_segment(it.now_time);
            end else begin
              r.command = CMD_RX_DONE;
              r.packet_length = in_total;
              last_poll_time = it.now_time;
              seq_state = ST_IDLE;
            end
          end else if (it.chan_status == CH_STALL) begin
            r.command = CMD_CLR_IN;
            seq_state = ST_IDLE;
          end else begin
            seq_state = ST_IDLE;
          end
        end
        default: begin
          if (it.chan_status == CH_DONE) begin
            if (out_total > out_next) begin
              r = send_next_segment();
            end else begin
              r.command = CMD_TX_DONE;
              r.packet_length = out_total;
              seq_state = ST_IDLE;
              out_total = '0;
              out_next = '0;
              out_prev = '0;
            end
          end else if (it.chan_status == CH_NAK) begin
            // resend the last segment if anything is left of it
            seg_len = '0;
            if (out_total > out_prev) seg_len = out_total - out_prev;
            if (seg_len > out_max) seg_len = 13'(out_max);
            if (seg_len != 0) begin
              r.command = CMD_RESEND;
              r.packet_offset = out_prev;
              r.packet_length = seg_len[11:0];
            end
          end else if (it.chan_status == CH_STALL) begin
            r.command = CMD_CLR_OUT;
            seq_state = ST_IDLE;
          end
        end
      endcase
    end
    case (seq_state)
      ST_IN:   r.state_now = STATE_CODE_IN;
      ST_OUT:  r.state_now = STATE_CODE_OUT;
      default: r.state_now = STATE_CODE_IDLE;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // drive one item, hold it until the transfer, then predict its result
  task automatic send_item(item_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    mode           <= it.mode;
    request_length <= it.request_length;
    connected      <= it.connected;
    chan_status    <= it.chan_status;
    now_time       <= it.now_time;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted_commands.push_back(segment_step(it));
    @(negedge clk);
  endtask

  task automatic post_request(mode_t m, logic [11:0] len);
    item_t it;
    it.mode = m;
    it.request_length = len;
    it.connected = 1'($urandom_range(0, 1));
    it.chan_status = chan_res_t'($urandom_range(0, 3));
    it.now_time = $urandom();
    send_item(it);
  endtask

  task automatic handler_step(chan_res_t u, logic conn);
    item_t it;
    it.mode = MODE_STEP;
    it.request_length = 12'($urandom_range(0, 4095));
    it.connected = conn;
    it.chan_status = u;
    it.now_time = tick;
    send_item(it);
  endtask

  task automatic send_ignored_item();
    item_t it;
    it.mode = mode_t'(MODE_IGNORED);
    it.request_length = 12'($urandom_range(0, 4095));
    it.connected = 1'($urandom_range(0, 1));
    it.chan_status = chan_res_t'($urandom_range(0, 3));
    it.now_time = $urandom();
    send_item(it);
  endtask

  // stop offering items until every predicted result has come back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (predicted_commands.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write all three registers on consecutive cycles, block idle
  task automatic write_config(logic [9:0] out_size, logic [9:0] in_size, logic [15:0] poll);
    cfg_write <= 1'b1;
    cfg_index <= CFG_OUT_PACKET_SIZE;
    cfg_data  <= {6'd0, out_size};
    @(negedge clk);
    cfg_index <= CFG_IN_PACKET_SIZE;
    cfg_data  <= {6'd0, in_size};
    @(negedge clk);
    cfg_index <= CFG_POLL_INTERVAL;
    cfg_data  <= poll;
    @(negedge clk);
    cfg_write <= 1'b0;
    out_max = out_size;
    in_max = in_size;
    poll_ticks = poll;
  endtask

  function automatic chan_res_t pick_status();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return CH_DONE;
    if (r < 85) return CH_NAK;
    if (r < 93) return CH_IDLE;
    return CH_STALL;
  endfunction

  // mostly a few packets long, sometimes anything
  function automatic logic [11:0] pick_length(logic [9:0] size);
    int r;
    int hi;
    r = $urandom_range(0, 99);
    if (r < 15) return 12'($urandom_range(0, 4095));
    if (r < 25) return 12'($urandom_range(0, 3));
    hi = 3 * size + 1;
    if (hi > 4095) hi = 4095;
    return 12'($urandom_range(0, hi));
  endfunction

  // out transfers: segmentation, nak resend, idle status, zero length, stall
  task automatic test_directed_out();
    tick = 32'd5;
    handler_step(CH_DONE, 1'b1);      // nothing pending, poll not due
    send_ignored_item();
    post_request(MODE_TX, 12'd130);
    handler_step(CH_DONE, 1'b0);      // disconnected: no effect
    handler_step(CH_IDLE, 1'b1);      // first segment
    handler_step(CH_NAK, 1'b1);       // resend it
    handler_step(CH_DONE, 1'b1);
    handler_step(CH_IDLE, 1'b1);      // stays in data out
    handler_step(CH_DONE, 1'b1);      // short tail segment
    handler_step(CH_DONE, 1'b1);      // tx done
    post_request(MODE_TX, 12'd0);
    handler_step(CH_DONE, 1'b1);      // zero length: no send
    handler_step(CH_NAK, 1'b1);       // nothing to resend
    handler_step(CH_DONE, 1'b1);
    post_request(MODE_TX, 12'd4095);
    handler_step(CH_DONE, 1'b1);
    handler_step(CH_STALL, 1'b1);     // clear out stall
  endtask

  // in transfers: later post replaces earlier, rx done
  task automatic test_directed_in();
    post_request(MODE_TX, 12'd4095);
    post_request(MODE_RX, 12'd100);
    handler_step(CH_IDLE, 1'b1);
    handler_step(CH_DONE, 1'b1);
    handler_step(CH_DONE, 1'b1);
  endtask

  // receive poll at the interval boundary and across time wrap
  task automatic test_directed_poll();
    tick = 32'd15;
    handler_step(CH_DONE, 1'b1);      // difference equals interval
    tick = 32'd16;
    handler_step(CH_DONE, 1'b1);      // poll starts
    handler_step(CH_DONE, 1'b1);
    tick = 32'hFFFF_FFFF;
    handler_step(CH_DONE, 1'b1);
    handler_step(CH_STALL, 1'b1);     // clear in stall
    tick = 32'd9;
    handler_step(CH_DONE, 1'b1);      // wrapped difference not above
  endtask

  // receiver holds off long enough for the block to fill and stall its input
  task automatic test_backpressure();
    quiet = 1'b1;
    hold_cycles = 60;
    post_request(MODE_TX, 12'd2000);
    repeat (12) handler_step(CH_DONE, 1'b1);
    wait_all_results();
    quiet = 1'b0;
  endtask

  task automatic run_traffic(int n_items);
    int    sent;
    int    steps;
    int    kind;
    mode_t m;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        // well-formed transfer with random content
        m = $urandom_range(0, 1) ? MODE_TX : MODE_RX;
        post_request(m, pick_length(m == MODE_TX ? out_max : in_max));
        sent++;
        steps = 0;
        do begin
          if ($urandom_range(0, 49) == 0) tick = $urandom();
          else tick = tick + $urandom_range(0, 15);
          if ($urandom_range(0, 19) == 0) begin
            handler_step(chan_res_t'($urandom_range(0, 3)), 1'b0);
          end else begin
            handler_step(pick_status(), 1'b1);
            sent++;
          end
          steps++;
        end while ((seq_state != ST_IDLE || seq_pending != REQ_NONE) && steps < 20);
      end else if (kind < 80) begin
        // idle steps with time jumps around the poll interval
        repeat ($urandom_range(1, 4)) begin
          tick = tick + $urandom_range(0, 2 * poll_ticks + 2);
          handler_step(pick_status(), 1'b1);
          sent++;
        end
      end else if (kind < 88) begin
        if ($urandom_range(0, 1)) send_ignored_item();
        else handler_step(chan_res_t'($urandom_range(0, 3)), 1'b0);
      end else if (kind < 96) begin
        // broken sequences: posts and steps out of order
        if ($urandom_range(0, 1)) begin
          post_request($urandom_range(0, 1) ? MODE_TX : MODE_RX, 12'($urandom_range(0, 4095)));
        end else begin
          handler_step(chan_res_t'($urandom_range(0, 3)), 1'b1);
        end
        sent++;
      end else if (!quiet) begin
        wait_all_results();
      end
    end
  endtask

  task automatic run_phase(logic [9:0] out_size, logic [9:0] in_size, logic [15:0] poll,
                           int n_items);
    wait_all_results();
    write_config(out_size, in_size, poll);
    run_traffic(n_items);
  endtask

  task automatic test_random_phases();
    run_phase(10'd512, 10'd512, 16'd0, 90);
    run_phase(10'd1, 10'd1, 16'hFFFF, 90);
    run_phase(10'd0, 10'd0, 16'd3, 50);
    run_phase(10'($urandom_range(1, 512)), 10'($urandom_range(1, 512)),
              16'($urandom_range(0, 65535)), 100);
    quiet = 1'b1;
    run_phase(OUT_PACKET_SIZE_RESET, IN_PACKET_SIZE_RESET, POLL_INTERVAL_RESET, 100);
  endtask

  // receiver stalls: random bursts, plus a counted long hold on request
  initial begin : out_stall_driver
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        stall_left = hold_cycles;
        hold_cycles = 0;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 18);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // compare each output transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (predicted_commands.size() == 0) begin
        report_mismatch($sformatf("unexpected result, command %0d", command));
      end else begin
        want = predicted_commands.pop_front();
        if (command !== want.command)
          report_mismatch($sformatf("command got %0d want %0d", command, want.command));
        if (packet_offset !== want.packet_offset)
          report_mismatch($sformatf("packet_offset got %0d want %0d",
                                    packet_offset, want.packet_offset));
        if (packet_length !== want.packet_length)
          report_mismatch($sformatf("packet_length got %0d want %0d",
                                    packet_length, want.packet_length));
        if (state_now !== want.state_now)
          report_mismatch($sformatf("state_now got %0d want %0d", state_now, want.state_now));
      end
    end
  end

  // run limit
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // test sequence
  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    mode           = MODE_STEP;
    request_length = '0;
    connected      = 1'b0;
    chan_status    = CH_IDLE;
    now_time       = '0;
    cfg_write      = 1'b0;
    cfg_index      = CFG_OUT_PACKET_SIZE;
    cfg_data       = '0;
    seq_state      = ST_IDLE;
    seq_pending    = REQ_NONE;
    out_total      = '0;
    out_next       = '0;
    out_prev       = '0;
    in_total       = '0;
    in_next        = '0;
    last_poll_time = '0;
    out_max        = OUT_PACKET_SIZE_RESET;
    in_max         = IN_PACKET_SIZE_RESET;
    poll_ticks     = POLL_INTERVAL_RESET;
    tick           = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_directed_out();
    test_directed_in();
    test_directed_poll();
    test_backpressure();
    test_random_phases();

    wait_all_results();
    repeat (10) @(negedge clk);
    if (error_count == 0 && predicted_commands.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
